// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the tempo map RTL.
// Depends on nothing; users must have i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds in the same cycle, checked outside reset.
`define TTM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("tempo map check failed");

// Property whose consequence is checked in the cycle after the antecedent.
`define TTM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tempo map sequence check failed");

`endif

// ===== rtl/core/ttm_pkg.sv =====
// Package for the tick-to-time tempo map: field widths, codes and shared types.
// Used by the controller, the datapath and the top level; depends on nothing.
package ttm_pkg;

    // Field widths fixed by the interface.
    localparam int CMD_W    = 2;
    localparam int TICK_W   = 28;
    localparam int TEMPO_W  = 24;
    localparam int TPQ_W    = 15;
    localparam int SUM_W    = 52;
    localparam int TIME_W   = 60;
    localparam int STATUS_W = 2;

    // Division register value after reset.
    localparam logic [TPQ_W-1:0] TPQ_RESET = 15'd480;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ORDER = 2'd3;

    // Input transaction.
    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [TICK_W-1:0]  tick;
        logic [TEMPO_W-1:0] usec_per_quarter;
    } t_in_item;

    // Result transaction.
    typedef struct packed {
        logic [TIME_W-1:0]   time_us_q8;
        logic [STATUS_W-1:0] status;
    } t_out_item;

    // One tempo table entry as stored in the table memory.
    typedef struct packed {
        logic [TICK_W-1:0]  start_tick;
        logic [TEMPO_W-1:0] tempo;
        logic [SUM_W-1:0]   cum;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                load;         // latch input item, set table index
        logic                clear_acc;    // zero product, base and quotient
        logic                set_status;   // load status_code into status reg
        logic [STATUS_W-1:0] status_code;
        logic                clear_count;  // empty the table
        logic                take;         // current entry becomes the best entry
        logic                idx_inc;      // step to the next table entry
        logic                mul;          // segment product from the best entry
        logic                app_write;    // write new entry, bump the count
        logic                div_init;     // form dividend and divisor
        logic                div_step;     // one restoring division step
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CMD_W-1:0] command;      // latched command code
        logic             count_zero;
        logic             count_full;
        logic             tick_lt_start; // item tick below entry read from table
        logic             idx_zero;
        logic             idx_last;
        logic             div_last;
    } t_dp_status;

endpackage

// ===== rtl/core/tick_to_time_tempo_map_top.sv =====
// Top level of the tick-to-time tempo map: controller, datapath and checks.
// Depends on ttm_pkg, ttm_ctrl, ttm_dp and assert_macros.svh.
//
//   Channel   Direction  Handshake               Payload
//   item      in         start, busy             i_item (ttm_pkg::t_in_item)
//   result    out        o_done (strobe)         o_result (ttm_pkg::t_out_item)
//   config    in         i_cfg_wr_en             i_cfg_data (ticks per quarter)
//
// A transaction is taken when start is high and busy is low; its result is
// strobed on o_done. A clear goes from decode straight to the strobe, an append
// to a non-empty table compares against the last entry before it writes, and a
// query scans the table entries, forms the product and sum, then divides: the
// search passes through S_CMP and S_WAIT for each entry read from the table RAM
// and the divider retires one quotient bit per cycle.
// Reset is synchronous and active low; the table holds no entries after it.
// The receiver cannot stall; a new transaction is taken while a result shows.
`include "assert_macros.svh"

module tick_to_time_tempo_map_top #(
    parameter int MAX_TEMPOS = 64,
    parameter int FRAC_BITS  = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  ttm_pkg::t_in_item         i_item,
    output logic                      o_done,
    output ttm_pkg::t_out_item        o_result,
    input  logic                      i_cfg_wr_en,
    input  logic [ttm_pkg::TPQ_W-1:0] i_cfg_data
);

    ttm_pkg::t_dp_cmd    w_cmd;
    ttm_pkg::t_dp_status w_stat;
    logic                w_err_result;

    // Controller.
    ttm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // Datapath.
    ttm_dp #(
        .MAX_TEMPOS (MAX_TEMPOS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_result    (o_result)
    );

    // A result with an error status is on the ports.
    assign w_err_result = o_done && (o_result.status != ttm_pkg::ST_OK);

    // An accepted transaction always occupies the block for the next cycle.
    `TTM_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

    // A result strobe never repeats in the following cycle.
    `TTM_ASSERT_NEXT(a_done_single, o_done, !o_done)

    // Any error status comes with a zero time value.
    `TTM_ASSERT(a_err_zero_time, w_err_result |-> (o_result.time_us_q8 == '0))

    // The table is never written once it is full.
    `TTM_ASSERT(a_no_write_full, w_cmd.app_write |-> !w_stat.count_full)

endmodule

// ===== rtl/core/ttm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Stands alone; holds the tempo table for the tempo map datapath.
module ttm_ram #(
    parameter int WIDTH = 104,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/ttm_ctrl.sv =====
// Controller state machine for the tick-to-time tempo map.
// Depends on ttm_pkg; drives the datapath through t_dp_cmd.
module ttm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    output logic                o_done,
    input  ttm_pkg::t_dp_status i_stat,
    output ttm_pkg::t_dp_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_CMP    = 4'd2;
    localparam logic [3:0] S_WAIT   = 4'd3;
    localparam logic [3:0] S_MUL    = 4'd4;
    localparam logic [3:0] S_APP_WR = 4'd5;
    localparam logic [3:0] S_SUM    = 4'd6;
    localparam logic [3:0] S_DIV    = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // A new transaction may start while the previous result is on the ports.
    assign busy   = (r_state != S_IDLE) && (r_state != S_DONE);
    assign o_done = (r_state == S_DONE);

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state) inside
            S_IDLE, S_DONE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DECODE: begin
                o_cmd.clear_acc   = 1'b1;
                o_cmd.set_status  = 1'b1;
                o_cmd.status_code = ttm_pkg::ST_OK;
                unique case (i_stat.command)
                    ttm_pkg::CMD_APPEND: begin
                        if (i_stat.count_full) begin
                            o_cmd.status_code = ttm_pkg::ST_FULL;
                            n_state           = S_DONE;
                        end else if (i_stat.count_zero) begin
                            n_state = S_APP_WR;
                        end else begin
                            n_state = S_CMP;
                        end
                    end
                    ttm_pkg::CMD_CLEAR: begin
                        o_cmd.clear_count = 1'b1;
                        n_state           = S_DONE;
                    end
                    ttm_pkg::CMD_QUERY: begin
                        if (i_stat.count_zero) begin
                            o_cmd.status_code = ttm_pkg::ST_EMPTY;
                            n_state           = S_DONE;
                        end else begin
                            n_state = S_CMP;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_CMP: begin
                if (i_stat.command == ttm_pkg::CMD_APPEND) begin
                    // Compare against the last entry in the table.
                    if (i_stat.tick_lt_start) begin
                        o_cmd.set_status  = 1'b1;
                        o_cmd.status_code = ttm_pkg::ST_ORDER;
                        n_state           = S_DONE;
                    end else begin
                        o_cmd.take = 1'b1;
                        n_state    = S_MUL;
                    end
                end else begin
                    // Linear search: keep the last entry at or before the tick.
                    if (!i_stat.tick_lt_start) begin
                        o_cmd.take = 1'b1;
                        if (i_stat.idx_last) begin
                            n_state = S_MUL;
                        end else begin
                            o_cmd.idx_inc = 1'b1;
                            n_state       = S_WAIT;
                        end
                    end else if (i_stat.idx_zero) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_WAIT: begin
                n_state = S_CMP;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                if (i_stat.command == ttm_pkg::CMD_APPEND) begin
                    n_state = S_APP_WR;
                end else begin
                    n_state = S_SUM;
                end
            end
            S_APP_WR: begin
                o_cmd.app_write = 1'b1;
                n_state         = S_DONE;
            end
            S_SUM: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_DONE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/core/ttm_dp.sv =====
// Datapath for the tick-to-time tempo map: table memory, search, product and divider.
// Depends on ttm_pkg and ttm_ram; steered by ttm_ctrl through t_dp_cmd.
module ttm_dp #(
    parameter int MAX_TEMPOS = 64,
    parameter int FRAC_BITS  = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ttm_pkg::t_in_item               i_item,
    input  logic                            i_cfg_wr_en,
    input  logic [ttm_pkg::TPQ_W-1:0]       i_cfg_data,
    input  ttm_pkg::t_dp_cmd                i_cmd,
    output ttm_pkg::t_dp_status             o_stat,
    output ttm_pkg::t_out_item              o_result
);

    localparam int AW    = (MAX_TEMPOS > 1) ? $clog2(MAX_TEMPOS) : 1;
    localparam int CW    = $clog2(MAX_TEMPOS + 1);
    localparam int DW    = ttm_pkg::SUM_W + FRAC_BITS;
    localparam int CNT_W = $clog2(DW + 1);
    localparam int EW    = $bits(ttm_pkg::t_entry);

    ttm_pkg::t_in_item                r_item;
    logic [AW-1:0]                    r_idx;
    logic [CW-1:0]                    r_count;
    logic [ttm_pkg::TPQ_W-1:0]        r_tpq;
    ttm_pkg::t_entry                  r_best;
    logic [ttm_pkg::SUM_W-1:0]        r_prod;
    logic [ttm_pkg::SUM_W-1:0]        r_base;
    logic [DW-1:0]                    r_work;
    logic [ttm_pkg::TPQ_W-1:0]        r_rem;
    logic [ttm_pkg::TPQ_W-1:0]        r_divisor;
    logic [CNT_W-1:0]                 r_cnt;
    logic [ttm_pkg::STATUS_W-1:0]     r_status;

    logic [CW-1:0]                    w_last_idx;
    logic [EW-1:0]                    w_rd_bits;
    ttm_pkg::t_entry                  w_rd_entry;
    ttm_pkg::t_entry                  w_wr_entry;
    logic [ttm_pkg::TICK_W-1:0]       w_delta;
    logic [ttm_pkg::SUM_W-1:0]        w_sum;
    logic [ttm_pkg::TPQ_W:0]          w_rem_shift;
    logic                             w_ge;
    logic [DW-1:0]                    n_work;
    logic [ttm_pkg::TPQ_W-1:0]        n_rem;

    // Tempo table memory: read at the search index, written at the fill count.
    ttm_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_TEMPOS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.app_write),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (w_wr_entry),
        .i_rd_addr (r_idx),
        .o_rd_data (w_rd_bits)
    );

    assign w_rd_entry = w_rd_bits;
    assign w_last_idx = r_count - CW'(1);
    assign w_sum      = r_base + r_prod;
    assign w_delta    = r_item.tick - r_best.start_tick;

    assign w_wr_entry.start_tick = r_item.tick;
    assign w_wr_entry.tempo      = r_item.usec_per_quarter;
    assign w_wr_entry.cum        = w_sum;

    // One restoring division step: shift in the next dividend bit.
    assign w_rem_shift = {r_rem, r_work[DW-1]};
    assign w_ge        = (w_rem_shift >= {1'b0, r_divisor});
    always_comb begin
        n_rem  = w_ge ? ttm_pkg::TPQ_W'(w_rem_shift - {1'b0, r_divisor})
                      : w_rem_shift[ttm_pkg::TPQ_W-1:0];
        n_work = {r_work[DW-2:0], w_ge};
    end

    // Status toward the controller.
    assign o_stat.command       = r_item.command;
    assign o_stat.count_zero    = (r_count == '0);
    assign o_stat.count_full    = (r_count == CW'(MAX_TEMPOS));
    assign o_stat.tick_lt_start = (r_item.tick < w_rd_entry.start_tick);
    assign o_stat.idx_zero      = (r_idx == '0);
    assign o_stat.idx_last      = ((CW'(r_idx) + CW'(1)) == r_count);
    assign o_stat.div_last      = (r_cnt == CNT_W'(1));

    // The quotient register holds zero for everything but a finished query.
    assign o_result.time_us_q8 = ttm_pkg::TIME_W'(r_work);
    assign o_result.status     = r_status;

    // Control state: fill count and division register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_tpq   <= ttm_pkg::TPQ_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_tpq <= i_cfg_data;
            end
            if (i_cmd.clear_count) begin
                r_count <= '0;
            end else if (i_cmd.app_write) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    // Item latch and search index.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
            if ((i_item.command == ttm_pkg::CMD_APPEND) && (r_count != '0)) begin
                r_idx <= w_last_idx[AW-1:0];
            end else begin
                r_idx <= '0;
            end
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + AW'(1);
        end
    end

    // Best entry found so far.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_best <= w_rd_entry;
        end
    end

    // Segment product and base sum.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_acc) begin
            r_prod <= '0;
            r_base <= '0;
        end else if (i_cmd.mul) begin
            r_prod <= ttm_pkg::SUM_W'(w_delta) * ttm_pkg::SUM_W'(r_best.tempo);
            r_base <= r_best.cum;
        end
    end

    // Status register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status_code;
        end
    end

    // Serial divider: dividend shifts out as the quotient shifts in.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_acc) begin
            r_work <= '0;
        end else if (i_cmd.div_init) begin
            r_work    <= DW'(w_sum) << FRAC_BITS;
            r_rem     <= '0;
            r_divisor <= (r_tpq == '0) ? ttm_pkg::TPQ_W'(1) : r_tpq;
            r_cnt     <= CNT_W'(DW);
        end else if (i_cmd.div_step) begin
            r_work <= n_work;
            r_rem  <= n_rem;
            r_cnt  <= r_cnt - CNT_W'(1);
        end
    end

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the tick-to-time tempo map top level.
// Depends on ttm_pkg and tick_to_time_tempo_map_top; checks every result
// against a predictor of the tempo table that the bench keeps itself.
`timescale 1ns / 1ps

module tb_top;
    import ttm_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int FRAC = 8;
    localparam int PHASE_ITEMS = 250;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 256;
    localparam int IDLE_PERCENT = 16;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [TICK_W-1:0] TICK_MAX = '1;
    localparam logic [TEMPO_W-1:0] TEMPO_MAX = '1;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_in_item item_in = '0;
    logic done;
    t_out_item result;
    logic cfg_wr_en = 1'b0;
    logic [TPQ_W-1:0] cfg_data = '0;

    // Commands waiting to be driven, and results the block still owes.
    t_in_item cmd_queue[$];
    t_out_item due_results[$];

    // Predicted tempo table and division register.
    logic [TICK_W-1:0] tbl_tick[TABLE_DEPTH];
    logic [TEMPO_W-1:0] tbl_tempo[TABLE_DEPTH];
    logic [SUM_W-1:0] tbl_sum[TABLE_DEPTH];
    int tbl_count = 0;
    logic [TPQ_W-1:0] tpq_setting = TPQ_RESET;

    int mismatch_count = 0;
    int stall_cycles = 0;
    bit no_gaps = 1'b0;

    tick_to_time_tempo_map_top #(
        .MAX_TEMPOS(TABLE_DEPTH),
        .FRAC_BITS (FRAC)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (item_in),
        .o_done     (done),
        .o_result   (result),
        .i_cfg_wr_en(cfg_wr_en),
        .i_cfg_data (cfg_data)
    );

    // 50 MHz clock.
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Applies one command to the predicted table and returns its result.
    function automatic t_out_item tempo_map_apply(input t_in_item cmd);
        t_out_item r;
        logic [63:0] acc;
        logic [63:0] divisor;
        int k;
        r.time_us_q8 = '0;
        r.status = ST_OK;
        case (cmd.command)
            CMD_APPEND: begin
                if (tbl_count >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else if (tbl_count > 0 && cmd.tick < tbl_tick[tbl_count-1]) begin
                    r.status = ST_ORDER;
                end else begin
                    acc = '0;
                    if (tbl_count > 0) begin
                        acc = 64'(tbl_sum[tbl_count-1])
                            + 64'(cmd.tick - tbl_tick[tbl_count-1])
                            * 64'(tbl_tempo[tbl_count-1]);
                    end
                    tbl_tick[tbl_count] = cmd.tick;
                    tbl_tempo[tbl_count] = cmd.usec_per_quarter;
                    tbl_sum[tbl_count] = acc[SUM_W-1:0];
                    tbl_count++;
                end
            end
            CMD_CLEAR: begin
                tbl_count = 0;
            end
            CMD_QUERY: begin
                if (tbl_count == 0) begin
                    r.status = ST_EMPTY;
                end else if (cmd.tick >= tbl_tick[0]) begin
                    // Last entry at or before the tick, plus the partial segment.
                    k = 0;
                    while (k + 1 < tbl_count && tbl_tick[k+1] <= cmd.tick) k++;
                    acc = 64'(tbl_sum[k])
                        + 64'(cmd.tick - tbl_tick[k]) * 64'(tbl_tempo[k]);
                    divisor = (tpq_setting == '0) ? 64'd1 : 64'(tpq_setting);
                    r.time_us_q8 = TIME_W'((acc << FRAC) / divisor);
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("ERROR at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Driver: predicts each accepted transaction and presents the next one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                due_results.insert(due_results.size(), tempo_map_apply(item_in));
            end
            if (!start || !busy) begin
                if (cmd_queue.size() != 0 &&
                    (no_gaps || $urandom_range(99) >= IDLE_PERCENT)) begin
                    start <= 1'b1;
                    item_in <= cmd_queue.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobed result is checked against the oldest prediction.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && done) begin
            if (due_results.size() == 0) begin
                flag_mismatch("unexpected result, status", 64'(result.status), 64'd0);
            end else begin
                want = due_results.pop_front();
                if (result.time_us_q8 !== want.time_us_q8) begin
                    flag_mismatch("time_us_q8", 64'(result.time_us_q8),
                                  64'(want.time_us_q8));
                end
                if (result.status !== want.status) begin
                    flag_mismatch("status", 64'(result.status), 64'(want.status));
                end
            end
        end
    end

    // Watchdog: ends the run if no transaction moves for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || done) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic queue_cmd(input logic [CMD_W-1:0] code, input logic [TICK_W-1:0] t,
                             input logic [TEMPO_W-1:0] tempo);
        t_in_item x;
        x.command = code;
        x.tick = t;
        x.usec_per_quarter = tempo;
        cmd_queue.insert(cmd_queue.size(), x);
    endtask

    function automatic logic [TEMPO_W-1:0] rand_tempo();
        case ($urandom_range(3))
            0: return TEMPO_W'($urandom_range(1000000, 250000));
            1: return TEMPO_W'($urandom_range(TEMPO_MAX, 1));
            2: return TEMPO_MAX;
            default: return TEMPO_W'($urandom_range(255, 1));
        endcase
    endfunction

    function automatic logic [TICK_W-1:0] rand_tick();
        return TICK_W'($urandom);
    endfunction

    // Next start tick at or after the previous one, clamped to the field.
    function automatic logic [TICK_W-1:0] next_tick(input logic [TICK_W-1:0] prev);
        logic [63:0] delta;
        logic [63:0] sum;
        case ($urandom_range(9))
            0: delta = 64'd0;
            1, 2, 3: delta = 64'($urandom_range(960, 1));
            4, 5: delta = 64'($urandom_range(100000, 1));
            6, 7, 8: delta = 64'($urandom & ((32'd1 << $urandom_range(28, 1)) - 1));
            default: delta = 64'(TICK_MAX);
        endcase
        sum = 64'(prev) + delta;
        return (sum > 64'(TICK_MAX)) ? TICK_MAX : sum[TICK_W-1:0];
    endfunction

    // Query tick around the entries of the current song.
    function automatic logic [TICK_W-1:0] query_tick(input logic [TICK_W-1:0] first,
                                                     input logic [TICK_W-1:0] last);
        logic [63:0] beyond;
        case ($urandom_range(5))
            0: return (first == '0) ? '0 : TICK_W'($urandom_range(first - 1, 0));
            1, 2: return TICK_W'($urandom_range(last, first));
            3: begin
                beyond = 64'(last) + 64'($urandom_range(5000, 1));
                return (beyond > 64'(TICK_MAX)) ? TICK_MAX : beyond[TICK_W-1:0];
            end
            4: return rand_tick();
            default: return ($urandom_range(1) != 0) ? last : first;
        endcase
    endfunction

    // One tempo map: usually a clear, then ordered appends and queries, with
    // some out-of-order appends, empty-table queries and unused codes mixed in.
    task automatic queue_song(input bit long_song);
        int n;
        logic [TICK_W-1:0] first;
        logic [TICK_W-1:0] last;
        logic [TICK_W-1:0] t;
        if ($urandom_range(9) != 0) begin
            queue_cmd(CMD_CLEAR, rand_tick(), rand_tempo());
            if ($urandom_range(3) == 0) queue_cmd(CMD_QUERY, rand_tick(), rand_tempo());
        end
        if ($urandom_range(19) == 0) queue_cmd(CMD_UNUSED, rand_tick(), rand_tempo());
        n = long_song ? $urandom_range(70, 60) : $urandom_range(10, 1);
        case ($urandom_range(2))
            0: first = '0;
            1: first = TICK_W'($urandom_range(10000, 0));
            default: first = rand_tick() >> $urandom_range(27, 0);
        endcase
        last = first;
        for (int i = 0; i < n; i++) begin
            if (i > 0 && last != '0 && $urandom_range(9) == 0) begin
                t = TICK_W'($urandom_range(last - 1, 0));
            end else begin
                t = (i == 0) ? first : next_tick(last);
                last = t;
            end
            queue_cmd(CMD_APPEND, t, rand_tempo());
            if ($urandom_range(3) == 0) queue_cmd(CMD_QUERY, query_tick(first, last), rand_tempo());
        end
        repeat ($urandom_range(6, 1)) queue_cmd(CMD_QUERY, query_tick(first, last), rand_tempo());
    endtask

    // Waits until every command has been driven and every result has come.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (cmd_queue.size() != 0 || start || due_results.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_tpq(input logic [TPQ_W-1:0] value);
        @(posedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        tpq_setting = value;
    endtask

    // Stimulus sequence.
    initial begin
        logic [TPQ_W-1:0] settings[6];
        int song_no;
        settings = '{15'd1, 15'd32767, 15'd0, 15'd960, 15'd0, 15'd480};
        settings[4] = TPQ_W'($urandom_range(32767, 1));
        song_no = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed checks under the reset division.
        queue_cmd(CMD_QUERY, 28'd1000, 24'd0);
        queue_cmd(CMD_UNUSED, TICK_MAX, TEMPO_MAX);
        queue_cmd(CMD_APPEND, 28'd100, 24'd500000);
        queue_cmd(CMD_QUERY, 28'd0, 24'd0);
        queue_cmd(CMD_QUERY, 28'd100, 24'd0);
        queue_cmd(CMD_APPEND, 28'd50, 24'd1);
        queue_cmd(CMD_APPEND, 28'd100, 24'd250000);
        queue_cmd(CMD_QUERY, 28'd100, 24'd0);
        queue_cmd(CMD_APPEND, 28'd1000, TEMPO_MAX);
        queue_cmd(CMD_QUERY, 28'd999, 24'd0);
        queue_cmd(CMD_QUERY, 28'd5000, 24'd0);
        queue_cmd(CMD_APPEND, TICK_MAX, 24'd0);
        queue_cmd(CMD_QUERY, TICK_MAX, 24'd0);
        queue_cmd(CMD_QUERY, TICK_MAX - 1, 24'd0);
        queue_cmd(CMD_CLEAR, 28'd0, 24'd0);
        queue_cmd(CMD_QUERY, 28'd0, 24'd0);
        queue_cmd(CMD_APPEND, 28'd0, TEMPO_MAX);
        queue_cmd(CMD_APPEND, TICK_MAX, 24'd1);
        queue_cmd(CMD_QUERY, TICK_MAX, 24'd0);
        queue_cmd(CMD_QUERY, 28'd1, 24'd0);
        queue_cmd(CMD_CLEAR, 28'd0, 24'd0);
        wait_idle();

        // Random tempo maps under a sweep of division settings; one phase
        // drives back to back without gaps.
        for (int p = 0; p < 6; p++) begin
            write_tpq(settings[p]);
            no_gaps = (p == 3);
            @(negedge i_clk);
            while (cmd_queue.size() < PHASE_ITEMS) begin
                queue_song(song_no % 12 == 5);
                song_no++;
            end
            wait_idle();
        end

        // Let any stray result show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
